// ===== sv/hcmm_pkg.sv =====
// Package for the handheld console memory map: item kinds, register slots, result type.
// No dependencies.
`default_nettype none
package hcmm_pkg;

    typedef enum logic [2:0] {
        KIND_READ   = 3'd0,
        KIND_WRITE  = 3'd1,
        KIND_BUTTON = 3'd2,
        KIND_INCR   = 3'd3,
        KIND_BOOT   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        FWD_NONE  = 2'd0,
        FWD_CART  = 2'd1,
        FWD_SOUND = 2'd2
    } fwd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DMA
    } state_t;

    // Source memory of a sprite DMA copy.
    typedef enum logic [1:0] {
        SRC_VRAM,
        SRC_WRAM0,
        SRC_WRAM1
    } dma_src_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] forward_target;
        logic       dma_from_cartridge;
    } result_t;

    localparam logic [4:0] R_SB   = 5'd0;
    localparam logic [4:0] R_SC   = 5'd1;
    localparam logic [4:0] R_DIV  = 5'd2;
    localparam logic [4:0] R_IF   = 5'd6;
    localparam logic [4:0] R_LY   = 5'd11;
    localparam logic [4:0] R_DMA  = 5'd13;
    localparam logic [4:0] R_NONE = 5'd31;
    localparam int         IO_DEPTH = 21;
    localparam int         OAM_DEPTH = 160;

    localparam logic [15:0] A_JOYP  = 16'hFF00;
    localparam logic [15:0] A_LY    = 16'hFF44;
    localparam logic [15:0] A_BOOT  = 16'hFF50;
    localparam logic [15:0] A_OAM_E = 16'hFE9F;
    localparam logic [15:0] A_SND_L = 16'hFF10;
    localparam logic [15:0] A_SND_H = 16'hFF26;

    // Maps an I/O address to its register slot.
    function automatic logic [4:0] io_slot(input logic [15:0] a);
        logic [4:0] s;
        s = R_NONE;
        unique case (a)
            16'hFF01: s = 5'd0;
            16'hFF02: s = 5'd1;
            16'hFF04: s = 5'd2;
            16'hFF05: s = 5'd3;
            16'hFF06: s = 5'd4;
            16'hFF07: s = 5'd5;
            16'hFF0F: s = 5'd6;
            16'hFF40: s = 5'd7;
            16'hFF41: s = 5'd8;
            16'hFF42: s = 5'd9;
            16'hFF43: s = 5'd10;
            16'hFF44: s = 5'd11;
            16'hFF45: s = 5'd12;
            16'hFF46: s = 5'd13;
            16'hFF47: s = 5'd14;
            16'hFF48: s = 5'd15;
            16'hFF49: s = 5'd16;
            16'hFF4A: s = 5'd17;
            16'hFF4B: s = 5'd18;
            16'hFFFF: s = 5'd19;
            default:  s = R_NONE;
        endcase
        return s;
    endfunction

    function automatic logic in_cart(input logic [15:0] a);
        return (a[15] == 1'b0) || (a[15:13] == 3'b101);
    endfunction

endpackage
`default_nettype wire

// ===== sv/handheld_console_memory_map.sv =====
// Top level of the handheld console memory map with sprite DMA.
// Depends on hcmm_pkg and hcmm_ram.
//
//  Channel   Direction  Handshake       Payload
//  in        input      valid / stall   kind, address, value, buttons
//  out       output     valid / stall   read_data, forward_target, dma_from_cartridge
//  cfg       input      valid / ready   cfg_data (test_mode)
//
// A write, button update, hook or boot load is answered from decode; a read of a RAM
// passes through ST_READ first, as the read of the memory port is registered.
// A DMA register write from RAM copies min(DMA_LENGTH, 160) bytes: the copy
// moves one byte a cycle through the source memory's single port into sprite RAM,
// then the last byte is written into sprite RAM and the result is posted.
// Reset clears control state and the I/O registers; the RAMs are not cleared.
// Input is stalled while a read or a copy is in progress or the result is not taken.
`default_nettype none
module handheld_console_memory_map
    import hcmm_pkg::*;
#(
    parameter int DMA_LENGTH = 160,
    parameter int BOOT_DEPTH = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  kind,
    input  wire logic [15:0] address,
    input  wire logic [7:0]  value,
    input  wire logic [7:0]  buttons,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       read_data,
    output logic [1:0]       forward_target,
    output logic             dma_from_cartridge,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data
);

    localparam int CopyLen = (DMA_LENGTH < OAM_DEPTH) ? DMA_LENGTH : OAM_DEPTH;

    // Control and small state.
    state_t     state_reg, state_next;
    logic       test_mode_reg;
    logic [1:0] joy_sel_reg, joy_sel_next;
    logic [7:0] held_reg, held_next;
    logic       overlay_reg, overlay_next;
    logic [7:0] io_reg [IO_DEPTH];
    logic       io_we;
    logic [4:0] io_waddr;
    logic [7:0] io_wdata;
    logic       out_valid_reg, out_valid_next;
    result_t    res_reg, res_next;
    logic [2:0] rsel_reg, rsel_next;      // which memory answers a pending read
    dma_src_t   dsrc_reg, dsrc_next;
    logic [7:0] dcnt_reg, dcnt_next;      // source index being read
    logic       dwr_reg, dwr_next;        // a source byte is arriving
    logic [7:0] dwa_reg, dwa_next;        // sprite RAM index for that byte

    // Memory ports.
    logic        vr_we, w0_we, w1_we, oam_we, hr_we, bt_we;
    logic [12:0] vr_a;
    logic [11:0] w0_a, w1_a;
    logic [7:0]  oam_a, bt_a;
    logic [6:0]  hr_a;
    logic [7:0]  vr_q, w0_q, w1_q, oam_q, hr_q, bt_q, oam_wd;

    hcmm_ram #(.DEPTH(8192), .AW(13)) u_vram (.clk(clk), .we(vr_we), .addr(vr_a),
        .wdata(value), .rdata(vr_q));
    hcmm_ram #(.DEPTH(4096), .AW(12)) u_wram0 (.clk(clk), .we(w0_we), .addr(w0_a),
        .wdata(value), .rdata(w0_q));
    hcmm_ram #(.DEPTH(4096), .AW(12)) u_wram1 (.clk(clk), .we(w1_we), .addr(w1_a),
        .wdata(value), .rdata(w1_q));
    hcmm_ram #(.DEPTH(OAM_DEPTH), .AW(8)) u_oam (.clk(clk), .we(oam_we), .addr(oam_a),
        .wdata(oam_wd), .rdata(oam_q));
    hcmm_ram #(.DEPTH(127), .AW(7)) u_hram (.clk(clk), .we(hr_we), .addr(hr_a),
        .wdata(value), .rdata(hr_q));
    hcmm_ram #(.DEPTH(256), .AW(8)) u_boot (.clk(clk), .we(bt_we), .addr(bt_a),
        .wdata(value), .rdata(bt_q));

    localparam logic [2:0] RS_BOOT = 3'd0, RS_VRAM = 3'd1, RS_W0 = 3'd2,
                           RS_W1 = 3'd3, RS_OAM = 3'd4, RS_HRAM = 3'd5;

    logic       accept;
    logic [4:0] slot;
    logic [3:0] pressed;
    logic [7:0] joy_val;
    logic [7:0] mem_q;
    logic [7:0] src_q;

    assign cfg_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign in_stall  = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign accept    = in_valid && !in_stall;
    assign slot      = io_slot(address);

    assign out_valid          = out_valid_reg;
    assign read_data          = res_reg.read_data;
    assign forward_target     = res_reg.forward_target;
    assign dma_from_cartridge = res_reg.dma_from_cartridge;

    // Joypad nibble from held buttons and select bits.
    always_comb
    begin
        pressed = 4'd0;
        if (!joy_sel_reg[0])
        begin
            pressed = pressed | {held_reg[1], held_reg[0], held_reg[2], held_reg[3]};
        end
        if (!joy_sel_reg[1])
        begin
            pressed = pressed | held_reg[7:4];
        end
        joy_val = {2'b00, joy_sel_reg, ~pressed};
    end

    // Read data selection for a pending memory read and for the DMA source.
    always_comb
    begin
        unique case (rsel_reg)
            RS_BOOT: mem_q = bt_q;
            RS_VRAM: mem_q = vr_q;
            RS_W0:   mem_q = w0_q;
            RS_W1:   mem_q = w1_q;
            RS_OAM:  mem_q = oam_q;
            default: mem_q = hr_q;
        endcase
        unique case (dsrc_reg)
            SRC_VRAM:  src_q = vr_q;
            SRC_WRAM0: src_q = w0_q;
            default:   src_q = w1_q;
        endcase
    end

    // Decode, sequencing and memory port control.
    always_comb
    begin
        state_next     = state_reg;
        joy_sel_next   = joy_sel_reg;
        held_next      = held_reg;
        overlay_next   = overlay_reg;
        out_valid_next = out_valid_reg && out_stall;
        res_next       = res_reg;
        rsel_next      = rsel_reg;
        dsrc_next      = dsrc_reg;
        dcnt_next      = dcnt_reg;
        dwr_next       = 1'b0;
        dwa_next       = dcnt_reg;
        io_we    = 1'b0;
        io_waddr = slot;
        io_wdata = value;
        vr_we = 1'b0; w0_we = 1'b0; w1_we = 1'b0;
        oam_we = 1'b0; hr_we = 1'b0; bt_we = 1'b0;
        vr_a  = address[12:0];
        w0_a  = address[11:0];
        w1_a  = address[11:0];
        oam_a = address[7:0];
        oam_wd = value;
        hr_a  = address[6:0];
        bt_a  = address[7:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next = 1'b1;
                    res_next = '{read_data: 8'h00, forward_target: FWD_NONE,
                                 dma_from_cartridge: 1'b0};
                    unique case (kind)
                        KIND_READ:
                        begin
                            res_next.read_data = 8'hFF;
                            priority if (overlay_reg && ({16'd0, address} < BOOT_DEPTH)
                                         && address < 16'h0100)
                            begin
                                rsel_next = RS_BOOT; out_valid_next = 1'b0;
                                state_next = ST_READ;
                            end
                            else if (in_cart(address))
                                res_next.forward_target = FWD_CART;
                            else if (address[15:13] == 3'b100)
                            begin
                                rsel_next = RS_VRAM; out_valid_next = 1'b0;
                                state_next = ST_READ;
                            end
                            else if (address[15:12] == 4'hC)
                            begin
                                rsel_next = RS_W0; out_valid_next = 1'b0;
                                state_next = ST_READ;
                            end
                            else if (address[15:12] == 4'hD)
                            begin
                                rsel_next = RS_W1; out_valid_next = 1'b0;
                                state_next = ST_READ;
                            end
                            else if (address[15:8] == 8'hFE && address <= A_OAM_E)
                            begin
                                rsel_next = RS_OAM; out_valid_next = 1'b0;
                                state_next = ST_READ;
                            end
                            else if (address[15:7] == 9'h1FF && address != 16'hFFFF)
                            begin
                                rsel_next = RS_HRAM; out_valid_next = 1'b0;
                                state_next = ST_READ;
                            end
                            else if (address == A_JOYP)
                                res_next.read_data = joy_val;
                            else if (address >= A_SND_L && address <= A_SND_H)
                                res_next.forward_target = FWD_SOUND;
                            else if (slot != R_NONE)
                                res_next.read_data = io_reg[slot];
                        end
                        KIND_WRITE:
                        begin
                            priority if (test_mode_reg && address == A_LY)
                                res_next.forward_target = FWD_NONE;
                            else if (in_cart(address))
                                res_next.forward_target = FWD_CART;
                            else if (address[15:13] == 3'b100)
                                vr_we = 1'b1;
                            else if (address[15:12] == 4'hC)
                                w0_we = 1'b1;
                            else if (address[15:12] == 4'hD)
                                w1_we = 1'b1;
                            else if (address[15:8] == 8'hFE && address <= A_OAM_E)
                                oam_we = 1'b1;
                            else if (address[15:7] == 9'h1FF && address != 16'hFFFF)
                                hr_we = 1'b1;
                            else if (address == A_JOYP)
                                joy_sel_next = value[5:4];
                            else if (address == A_BOOT)
                            begin
                                if (value != 8'd0)
                                    overlay_next = 1'b0;
                            end
                            else if (address >= A_SND_L && address <= A_SND_H)
                                res_next.forward_target = FWD_SOUND;
                            else if (slot != R_NONE)
                            begin
                                io_we = 1'b1;
                                io_wdata = (slot == R_DIV) ? 8'h00 : value;
                                if (slot == R_DMA)
                                begin
                                    // Start a copy from the page value*0x100 when it lies in VRAM or WRAM.
                                    priority if (in_cart({value, 8'h00}))
                                        res_next.dma_from_cartridge = 1'b1;
                                    else if (value[7:5] == 3'b100 || value[7:4] == 4'hC
                                             || value[7:4] == 4'hD)
                                    begin
                                        dsrc_next = (value[7:5] == 3'b100) ? SRC_VRAM :
                                                    (value[7:4] == 4'hC) ? SRC_WRAM0 :
                                                    SRC_WRAM1;
                                        dcnt_next = 8'd0;
                                        out_valid_next = 1'b0;
                                        state_next = ST_DMA;
                                    end
                                    else
                                        dsrc_next = dsrc_reg;
                                end
                            end
                        end
                        KIND_BUTTON:
                        begin
                            if (buttons != held_reg)
                            begin
                                io_we = 1'b1; io_waddr = R_IF;
                                io_wdata = io_reg[R_IF] | 8'h10;
                            end
                            held_next = buttons;
                        end
                        KIND_INCR:
                        begin
                            if (address < 16'h7FFF)
                                res_next.forward_target = FWD_CART;
                            else if (address == A_LY)
                            begin
                                io_we = 1'b1; io_waddr = R_LY;
                                io_wdata = io_reg[R_LY] + 8'd1;
                            end
                        end
                        KIND_BOOT:
                        begin
                            if (({16'd0, address} < BOOT_DEPTH) && address < 16'h0100)
                                bt_we = 1'b1;
                        end
                        default: res_next = res_next;
                    endcase
                end
            end
            ST_READ:
            begin
                res_next.read_data = mem_q;
                out_valid_next = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                // Copy: read source index dcnt, write each byte into sprite RAM as it arrives from the registered read.
                vr_a  = {io_reg[R_DMA][4:0], dcnt_reg};
                w0_a  = {io_reg[R_DMA][3:0], dcnt_reg};
                w1_a  = {io_reg[R_DMA][3:0], dcnt_reg};
                oam_a = dwa_reg;
                oam_wd = src_q;
                oam_we = dwr_reg;
                if ({24'd0, dcnt_reg} < CopyLen)
                begin
                    dwr_next  = 1'b1;
                    dwa_next  = dcnt_reg;
                    dcnt_next = dcnt_reg + 8'd1;
                end
                else if (!dwr_reg)
                begin
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            test_mode_reg <= 1'b0;
            joy_sel_reg   <= 2'd0;
            held_reg      <= 8'd0;
            overlay_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
            dwr_reg       <= 1'b0;
            for (int i = 0; i < IO_DEPTH; i++)
            begin
                io_reg[i] <= 8'd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            joy_sel_reg   <= joy_sel_next;
            held_reg      <= held_next;
            overlay_reg   <= overlay_next;
            out_valid_reg <= out_valid_next;
            dwr_reg       <= dwr_next;
            if (cfg_valid && cfg_ready)
            begin
                test_mode_reg <= cfg_data;
            end
            if (io_we)
            begin
                io_reg[io_waddr] <= io_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        rsel_reg <= rsel_next;
        dsrc_reg <= dsrc_next;
        dcnt_reg <= dcnt_next;
        dwa_reg  <= dwa_next;
    end

endmodule
`default_nettype wire

// ===== sv/hcmm_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`default_nettype none
module hcmm_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] addr,
    input  wire logic [7:0]    wdata,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    // Write first takes no effect on the same-cycle read; callers never overlap them.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

// ===== sv/hcmm_checker.sv =====
// Port-level checker for the handheld console memory map, bound to the top level.
// Depends on hcmm_pkg.
`default_nettype none
module hcmm_checker
    import hcmm_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic [2:0] kind,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] read_data,
    input wire logic [1:0] forward_target,
    input wire logic       dma_from_cartridge,
    input wire logic       cfg_ready
);

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_data)
        && $stable(forward_target) && $stable(dma_from_cartridge))
        else $error("result changed while stalled");

    // Forward target never takes the unused code.
    a_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> forward_target != 2'd3)
        else $error("bad forward target");

    // A transfer that is neither a read nor a write answers with zero data the next cycle.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && kind != KIND_READ && kind != KIND_WRITE
        |=> out_valid && read_data == 8'h00)
        else $error("non-read item returned data");

    // Configuration is only taken while idle with no result pending.
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !out_valid)
        else $error("config ready while result pending");

endmodule

bind handheld_console_memory_map hcmm_checker u_hcmm_checker (.*);
`default_nettype wire
